// ----- hdl/assert_macros.svh -----
// Concurrent assertion helpers; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define STFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define STFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STFS_ASSERT(lbl, prop, msg)

`define STFS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- hdl/stfs_pkg.sv -----
package stfs_pkg;

  localparam int DEPTH       = 1024;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int ENTRY_IDX_W = 10;
  localparam int TIME_W      = 64;
  localparam int FLOOR_W     = 10;
  localparam int ECNT_W      = 11;
  localparam int CFG_IDX_W   = 2;

  localparam int IN_FIELD_W  = ENTRY_IDX_W + TIME_W;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((FLOOR_W + 7) / 8) * 8;

  typedef enum logic {
    MODE_WRITE  = 1'b0,
    MODE_SEARCH = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 2'd0,
    REG_LOWER_BOUND = 2'd1,
    REG_BOUND_EN    = 2'd2
  } cfg_reg_e;

  typedef logic [1:0] step_t;

  typedef enum logic [1:0] {
    J_NO_SEARCH,
    J_DONE,
    J_NOT_EQUAL,
    J_BUSY
  } jcond_e;

  typedef struct packed {
    logic   accept;
    logic   probe;
    logic   compare;
    logic   finish;
    jcond_e cond;
    step_t  target;
  } ctrl_word_t;

  typedef struct packed {
    logic search_go;
    logic done;
    logic equal;
    logic busy;
  } dp_stat_t;

  localparam step_t STEP_ACCEPT  = 2'd0;
  localparam step_t STEP_PROBE   = 2'd1;
  localparam step_t STEP_COMPARE = 2'd2;
  localparam step_t STEP_FINISH  = 2'd3;

  localparam ctrl_word_t UCODE [4] = '{
    '{accept: 1'b1, probe: 1'b0, compare: 1'b0, finish: 1'b0,
      cond: J_NO_SEARCH, target: STEP_ACCEPT},
    '{accept: 1'b0, probe: 1'b1, compare: 1'b0, finish: 1'b0,
      cond: J_DONE, target: STEP_FINISH},
    '{accept: 1'b0, probe: 1'b0, compare: 1'b1, finish: 1'b0,
      cond: J_NOT_EQUAL, target: STEP_PROBE},
    '{accept: 1'b0, probe: 1'b0, compare: 1'b0, finish: 1'b1,
      cond: J_BUSY, target: STEP_FINISH}
  };

endpackage

// ----- hdl/stfs_ram.sv -----
module stfs_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/stfs_seq.sv -----
`include "assert_macros.svh"

module stfs_seq
  import stfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_stat_t   stat,
  output ctrl_word_t ctrl
);

  step_t upc_r;
  step_t upc_nxt;
  logic  take;

  assign ctrl = UCODE[upc_r];

  always_comb begin
    unique case (ctrl.cond)
      J_NO_SEARCH: take = !stat.search_go;
      J_DONE:      take = stat.done;
      J_NOT_EQUAL: take = !stat.equal;
      J_BUSY:      take = stat.busy;
      default:     take = 1'b0;
    endcase
    upc_nxt = take ? ctrl.target : upc_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_ACCEPT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  `STFS_ASSERT(a_finish_returns, (ctrl.finish && !stat.busy) |=> (upc_r == STEP_ACCEPT), "finish step did not return to accept")
  `STFS_ASSERT(a_search_enters_probe, (ctrl.accept && stat.search_go) |=> ctrl.probe, "search word did not start probing")
  `STFS_ASSERT_ALWAYS(a_reset_to_accept, !rst_n |=> (upc_r == STEP_ACCEPT), "reset left sequencer off accept")

endmodule

// ----- hdl/stfs_dpath.sv -----
`include "assert_macros.svh"

module stfs_dpath
  import stfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_word_t             ctrl,
  output dp_stat_t               stat,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIME_W-1:0]      cfg_data,
  input  logic                   in_valid,
  input  logic                   in_mode,
  input  logic [ENTRY_IDX_W-1:0] in_entry_index,
  input  logic [TIME_W-1:0]      in_time_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FLOOR_W-1:0]     out_floor_index,
  output logic                   out_table_absent
);

  localparam int CMP_W = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
  localparam logic signed [TIME_W-1:0] BEST_INIT = TIME_W'(-2);

  logic [ECNT_W-1:0]        entry_count_r;
  logic signed [TIME_W-1:0] lower_bound_r;
  logic                     bound_en_r;

  logic signed [TIME_W-1:0] key_r, key_nxt;
  logic signed [TIME_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic                     found_r, found_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;
  logic                     absent_r, absent_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [FLOOR_W-1:0]       floor_r, floor_nxt;
  logic                     out_absent_r, out_absent_nxt;

  logic [CMP_W-1:0]         count_ext;
  logic [CNT_W-1:0]         count_sat;
  logic [CNT_W:0]           mid_sum;
  logic [IDX_W-1:0]         mid_c;
  logic [IDX_W-1:0]         ram_addr;
  logic                     ram_we;
  logic [TIME_W-1:0]        ram_rdata;
  logic signed [TIME_W-1:0] obj;
  logic                     take_word;
  logic                     busy;
  logic                     load_out;
  logic                     drop_floor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      lower_bound_r <= '0;
      bound_en_r    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_ENTRY_COUNT: entry_count_r <= cfg_data[ECNT_W-1:0];
        REG_LOWER_BOUND: lower_bound_r <= cfg_data;
        REG_BOUND_EN:    bound_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign count_ext = CMP_W'(entry_count_r);
  assign count_sat = (count_ext > CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(count_ext);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_c   = IDX_W'(mid_sum >> 1);

  assign take_word = ctrl.accept && in_valid;
  assign ram_we    = take_word && (mode_e'(in_mode) == MODE_WRITE)
                     && (32'(in_entry_index) < 32'(DEPTH));
  assign ram_addr  = ctrl.accept ? IDX_W'(in_entry_index) : mid_c;

  stfs_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_time_value),
    .rdata (ram_rdata)
  );

  assign obj  = signed'(ram_rdata);
  assign busy = out_valid_r && !out_ready;

  assign stat.search_go = take_word && (mode_e'(in_mode) == MODE_SEARCH);
  assign stat.done      = lo_r >= hi_r;
  assign stat.equal     = key_r == obj;
  assign stat.busy      = busy;

  assign load_out   = ctrl.finish && !busy;
  assign drop_floor = !found_r || (bound_en_r && (best_r < lower_bound_r));

  always_comb begin
    key_nxt        = key_r;
    best_nxt       = best_r;
    pos_nxt        = pos_r;
    found_nxt      = found_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    absent_nxt     = absent_r;
    floor_nxt      = floor_r;
    out_absent_nxt = out_absent_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (stat.search_go) begin
      key_nxt    = signed'(in_time_value);
      best_nxt   = BEST_INIT;
      pos_nxt    = '0;
      found_nxt  = 1'b0;
      lo_nxt     = '0;
      hi_nxt     = count_sat;
      absent_nxt = (count_sat == '0);
    end

    if (ctrl.probe) begin
      mid_nxt = mid_c;
    end

    if (ctrl.compare) begin
      if ((obj <= key_r) && (obj > best_r)) begin
        best_nxt  = obj;
        pos_nxt   = mid_r;
        found_nxt = 1'b1;
      end
      if (key_r < obj) begin
        hi_nxt = CNT_W'(mid_r);
      end else if (key_r > obj) begin
        lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
      end
    end

    if (load_out) begin
      floor_nxt      = drop_floor ? '0 : FLOOR_W'(pos_r);
      out_absent_nxt = absent_r;
      out_valid_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      found_r     <= found_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    best_r       <= best_nxt;
    pos_r        <= pos_nxt;
    mid_r        <= mid_nxt;
    absent_r     <= absent_nxt;
    floor_r      <= floor_nxt;
    out_absent_r <= out_absent_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_floor_index  = floor_r;
  assign out_table_absent = out_absent_r;

  `STFS_ASSERT(a_probe_in_range, ctrl.compare |-> (lo_r < hi_r), "probe with empty search range")
  `STFS_ASSERT(a_hi_within_depth, hi_r <= CNT_W'(DEPTH), "upper bound beyond table depth")
  `STFS_ASSERT(a_best_not_above_key, found_r |-> (best_r <= key_r), "best entry above search key")
  `STFS_ASSERT(a_absent_no_floor, (out_valid_r && out_absent_r) |-> (floor_r == '0), "absent table with nonzero floor")

endmodule

// ----- hdl/sorted_time_floor_search_top.sv -----
// Channel | Direction | Handshake          | Payload
// in_     | slave     | in_tvalid/tready   | tdata: entry_index, time_value; tuser: mode
// out_    | master    | out_tvalid/tready  | tdata: floor_index; tuser: table_absent
// cfg_    | slave     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A write word is stored while the sequencer stays at its accept step. A search word
// alternates a probe (table read) and a compare until a probe matches the key or the
// range runs out, at most floor(log2(count)) + 1 probes, then goes to the finish step.
// Reset is synchronous, active low; the table holds no reset value.
// The finished result moves into an output register; while an older result still
// waits there, the sequencer holds at its final step and takes no input.
module sorted_time_floor_search_top
  import stfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] entry_index, [73:10] time_value
  input  logic [0:0]            in_tuser,   // [0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] floor_index
  output logic [0:0]            out_tuser,  // [0] table_absent
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data
);

  ctrl_word_t         ctrl;
  dp_stat_t           stat;
  logic [FLOOR_W-1:0] floor_index;
  logic               table_absent;

  assign cfg_ready = 1'b1;
  assign in_tready = ctrl.accept;

  stfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  stfs_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_tvalid),
    .in_mode          (in_tuser[0]),
    .in_entry_index   (in_tdata[ENTRY_IDX_W-1:0]),
    .in_time_value    (in_tdata[IN_FIELD_W-1:ENTRY_IDX_W]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_floor_index  (floor_index),
    .out_table_absent (table_absent)
  );

  assign out_tdata = OUT_DATA_W'(floor_index);
  assign out_tuser = table_absent;

endmodule
